@@ rtl/core/bps16_pkg.sv @@
package bps16_pkg;

  localparam int ELEM_BYTES  = 16;
  localparam int BLOCK_ELEMS = 8;
  localparam int WORD_W      = 64;
  localparam int SRC_W       = $clog2(ELEM_BYTES);
  localparam int ELEM_IDX_W  = $clog2(BLOCK_ELEMS);
  localparam int CNT_W       = 17;
  localparam int BLK_IDX_W   = 16;
  localparam int BASE_W      = 23;
  localparam int STEP_W      = CNT_W + ELEM_IDX_W;
  localparam int MAX_BLOCKS  = 65536;

  localparam logic [ELEM_IDX_W-1:0] LAST_ELEM = ELEM_IDX_W'(BLOCK_ELEMS - 1);
  localparam logic [SRC_W-1:0]      LAST_BYTE = SRC_W'(ELEM_BYTES - 1);
  localparam logic [CNT_W-1:0]      CNT_RESET = CNT_W'(1);

  // Two completed blocks may wait between front and back.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [WORD_W-1:0] elem_lo;
    logic [WORD_W-1:0] elem_hi;
  } elem_t;

  typedef struct packed {
    logic [SRC_W-1:0]  source_byte;
    logic [WORD_W-1:0] planes;
    logic [BASE_W-1:0] dest_base;
    logic              last;
  } res_t;

  typedef logic [ELEM_BYTES-1:0][WORD_W-1:0] planes_t;

  typedef struct packed {
    planes_t                planes;
    logic [BLK_IDX_W-1:0]   block_index;
    logic [STEP_W-1:0]      step;
  } qentry_t;

  typedef struct packed {
    logic    valid;
    qentry_t entry;
  } qpush_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Zero acts as one, anything past MAX_BLOCKS saturates.
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] c;
    c = cnt;
    if (c == '0) c = CNT_W'(1);
    if (c > CNT_W'(MAX_BLOCKS)) c = CNT_W'(MAX_BLOCKS);
    return c;
  endfunction

  // Bit i of source byte b lands in bit col of plane byte i of entry b.
  function automatic planes_t scatter(input planes_t cur, input elem_t elem,
                                      input logic [ELEM_IDX_W-1:0] col);
    planes_t   p;
    logic [7:0] byte_v;
    p = cur;
    for (int b = 0; b < ELEM_BYTES; b++) begin
      if (b < 8) byte_v = elem.elem_lo[b*8 +: 8];
      else byte_v = elem.elem_hi[(b-8)*8 +: 8];
      for (int i = 0; i < 8; i++) begin
        for (int k = 0; k < BLOCK_ELEMS; k++) begin
          if (col == ELEM_IDX_W'(k)) p[b][i*8 + k] = byte_v[i];
        end
      end
    end
    return p;
  endfunction

endpackage

@@ rtl/core/bps16_front.sv @@
module bps16_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         elem_valid,
  output logic                         elem_stall,
  input  bps16_pkg::elem_t             elem_data,
  input  logic [bps16_pkg::CNT_W-1:0]  block_count,
  input  bps16_pkg::qstat_t            qstat,
  output bps16_pkg::qpush_t            qpush
);

  logic [bps16_pkg::ELEM_IDX_W-1:0] elem_idx;
  logic [bps16_pkg::BLK_IDX_W-1:0]  block_index;
  bps16_pkg::planes_t               buffer;
  bps16_pkg::planes_t               merged;
  logic [bps16_pkg::CNT_W-1:0]      stride;
  logic [bps16_pkg::CNT_W-1:0]      idx_inc;
  logic                             accept;
  logic                             block_done;

  // Only the closing element of a block needs room in the queue.
  assign elem_stall = (elem_idx == bps16_pkg::LAST_ELEM) && qstat.full;
  assign accept     = elem_valid && !elem_stall;
  assign block_done = accept && (elem_idx == bps16_pkg::LAST_ELEM);

  assign merged  = bps16_pkg::scatter(buffer, elem_data, elem_idx);
  assign stride  = bps16_pkg::eff_count(block_count);
  assign idx_inc = {1'b0, block_index} + bps16_pkg::CNT_W'(1);

  always_comb begin
    qpush.valid             = block_done;
    qpush.entry.planes      = merged;
    qpush.entry.block_index = block_index;
    qpush.entry.step        = {stride, bps16_pkg::ELEM_IDX_W'(0)};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_idx    <= '0;
      block_index <= '0;
    end else if (accept) begin
      elem_idx <= elem_idx + bps16_pkg::ELEM_IDX_W'(1);
      if (block_done) begin
        if (idx_inc >= stride) block_index <= '0;
        else block_index <= idx_inc[bps16_pkg::BLK_IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) buffer <= merged;
  end

endmodule

@@ rtl/core/bps16_queue.sv @@
module bps16_queue (
  input  logic                clk,
  input  logic                rst,
  input  bps16_pkg::qpush_t   qpush,
  input  logic                pop,
  output bps16_pkg::qstat_t   qstat,
  output bps16_pkg::qentry_t  head
);

  bps16_pkg::qentry_t             slots [bps16_pkg::Q_DEPTH];
  logic [bps16_pkg::Q_PTR_W-1:0]  wr_ptr;
  logic [bps16_pkg::Q_PTR_W-1:0]  rd_ptr;
  logic [bps16_pkg::Q_CNT_W-1:0]  count;
  logic                           do_push;
  logic                           do_pop;

  assign qstat.full  = (count == bps16_pkg::Q_CNT_W'(bps16_pkg::Q_DEPTH));
  assign qstat.empty = (count == '0);
  assign do_push     = qpush.valid && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + bps16_pkg::Q_PTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + bps16_pkg::Q_PTR_W'(1);
      unique case ({do_push, do_pop})
        2'b10:   count <= count + bps16_pkg::Q_CNT_W'(1);
        2'b01:   count <= count - bps16_pkg::Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= qpush.entry;
  end

endmodule

@@ rtl/core/bps16_back.sv @@
module bps16_back (
  input  logic                clk,
  input  logic                rst,
  input  bps16_pkg::qstat_t   qstat,
  input  bps16_pkg::qentry_t  head,
  output logic                pop,
  output logic                res_valid,
  input  logic                res_stall,
  output bps16_pkg::res_t     res_data
);

  logic [bps16_pkg::SRC_W-1:0]  src;
  logic [bps16_pkg::BASE_W-1:0] acc;
  logic [bps16_pkg::BASE_W-1:0] cur_base;
  logic                         load_ok;
  logic                         emit;

  assign load_ok  = !res_valid || !res_stall;
  assign emit     = load_ok && !qstat.empty;
  assign pop      = emit && (src == bps16_pkg::LAST_BYTE);
  assign cur_base = (src == '0) ? bps16_pkg::BASE_W'(head.block_index) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      src       <= '0;
    end else begin
      if (load_ok) res_valid <= emit;
      if (emit) src <= src + bps16_pkg::SRC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      acc                  <= cur_base + bps16_pkg::BASE_W'(head.step);
      res_data.source_byte <= src;
      res_data.planes      <= head.planes[src];
      res_data.dest_base   <= cur_base;
      res_data.last        <= (src == bps16_pkg::LAST_BYTE);
    end
  end

endmodule

@@ rtl/core/bit_plane_shuffle_16byte_core.sv @@
// Bit-plane transpose of 16-byte elements in blocks of eight. The front takes
// one element per cycle unless a block's last element meets a full queue, and
// scatters its 128 bits into one column of a block buffer; the eighth element
// closes the block and moves it into a two-block queue. The back then drives
// 16 results, one per source byte and one per cycle while res_stall is low,
// with the destination base of plane byte 0 (plane byte j sits at base plus
// j times the block count). A block has 8 elements but 16 results, so the
// sustained rate is set by the single result port. With the result port
// stalled, the queue holds two closed blocks and the buffer takes seven more
// elements before the input stalls. Each closed block passes through the
// queue, then the result register. block_count is written through
// cfg_valid/cfg_data (always ready) and should change only while idle.
module bit_plane_shuffle_16byte_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         elem_valid,
  output logic                         elem_stall,
  input  bps16_pkg::elem_t             elem_data,
  output logic                         res_valid,
  input  logic                         res_stall,
  output bps16_pkg::res_t              res_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bps16_pkg::CNT_W-1:0]  cfg_data
);

  logic [bps16_pkg::CNT_W-1:0] block_count;
  bps16_pkg::qpush_t           qpush;
  bps16_pkg::qstat_t           qstat;
  bps16_pkg::qentry_t          head;
  logic                        pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= bps16_pkg::CNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      block_count <= cfg_data;
    end
  end

  bps16_front u_front (
    .clk         (clk),
    .rst         (rst),
    .elem_valid  (elem_valid),
    .elem_stall  (elem_stall),
    .elem_data   (elem_data),
    .block_count (block_count),
    .qstat       (qstat),
    .qpush       (qpush)
  );

  bps16_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .qpush (qpush),
    .pop   (pop),
    .qstat (qstat),
    .head  (head)
  );

  bps16_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    qpush.valid |-> !qstat.full)
    else $error("block pushed into full queue");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (qpush.valid && qstat.empty) |=> !qstat.empty)
    else $error("completed block lost");

  a_last_marks_final: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_data.last == (res_data.source_byte == bps16_pkg::LAST_BYTE)))
    else $error("last flag out of step with source byte");

  a_pop_only_at_end: assert property (@(posedge clk) disable iff (rst)
    pop |=> (res_valid && res_data.last))
    else $error("queue head released before final result");
`endif

endmodule
